### rtl/csu_pkg.sv
// Shared constants and types for the chi-square uniformity test block.
package csu_pkg;

    localparam int NUM_CLASSES_DEF = 10;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int SAMPLE_W  = 8;
    localparam int CHI_W     = 40;
    localparam int TOTAL_W   = 16;
    localparam int EXP_W     = 13;
    localparam int FRAC_BITS = 8;
    localparam int SUM_W     = 64;
    localparam int DIV_W     = SUM_W + FRAC_BITS;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [EXP_W-1:0]   EXP_MAX   = '1;
    localparam logic [CHI_W-1:0]   CHI_MAX   = '1;

    localparam int                 APB_ADDR_W = 4;
    localparam int                 APB_DATA_W = 64;
    localparam logic               REG_CRIT   = 1'b0;   // register index, paddr[3]
    localparam logic [CHI_W-1:0]   CRIT_RESET = 40'd4332;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXP,
        S_SQ,
        S_ACC,
        S_CHI_GO,
        S_CHI_WAIT,
        S_OUT
    } t_state;

endpackage

### rtl/csu_ifs.sv
// Valid/ready channel interfaces for samples and results.
interface csu_sample_if import csu_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_value;
    logic                last_sample;

    modport source (output valid, sample_value, last_sample, input ready);
    modport sink   (input valid, sample_value, last_sample, output ready);
endinterface

interface csu_result_if import csu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CHI_W-1:0]   chi_stat;
    logic [TOTAL_W-1:0] total_count;
    logic [EXP_W-1:0]   expected_count;
    logic               accepted;
    logic               divide_error;

    modport source (output valid, chi_stat, total_count, expected_count, accepted,
                    divide_error, input ready);
    modport sink   (input valid, chi_stat, total_count, expected_count, accepted,
                    divide_error, output ready);
endinterface

### rtl/csu_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module csu_div import csu_pkg::*; #(
    parameter int DDW = DIV_W,
    parameter int DVW = COUNT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DDW-1:0]             i_dividend,
    input  logic [DVW-1:0]             i_divisor,
    input  logic [$clog2(DDW+1)-1:0]   i_steps,
    output logic                       o_done,
    output logic [DDW-1:0]             o_quotient
);
    localparam int STEP_W = $clog2(DDW+1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DVW-1:0]    r_rem;
    logic [DDW-1:0]    r_quo;
    logic [DVW-1:0]    r_dvs;

    logic [DVW:0]      n_shift;
    logic [DVW:0]      n_diff;
    logic              n_ge;
    logic [DVW-1:0]    n_rem;
    logic [DDW-1:0]    n_quo;

    // dividend bits leave at the top while quotient bits enter at the bottom
    always_comb begin
        n_shift = {r_rem, r_quo[DDW-1]};
        n_ge    = (n_shift >= {1'b0, r_dvs});
        n_diff  = n_shift - {1'b0, r_dvs};
        n_rem   = n_ge ? n_diff[DVW-1:0] : n_shift[DVW-1:0];
        n_quo   = {r_quo[DDW-2:0], n_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### rtl/csu_cnt.sv
// Saturating class counters and run total, with one indexed read port.
module csu_cnt import csu_pkg::*; #(
    parameter int N = NUM_CLASSES_DEF,
    parameter int W = COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_inc,
    input  logic [$clog2(N)-1:0] i_cls,
    input  logic                 i_clr,
    input  logic [$clog2(N)-1:0] i_rd_idx,
    output logic [W-1:0]         o_rd_data,
    output logic [W-1:0]         o_total
);
    localparam int IDX_W = $clog2(N);

    logic [W-1:0] r_cnt [N];
    logic [W-1:0] r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            for (int k = 0; k < N; k++) begin
                r_cnt[k] <= '0;
            end
            r_total <= '0;
        end else if (i_inc) begin
            for (int k = 0; k < N; k++) begin
                if (i_cls == IDX_W'(k) && r_cnt[k] != '1) begin
                    r_cnt[k] <= r_cnt[k] + 1'b1;
                end
            end
            if (r_total != '1) begin
                r_total <= r_total + 1'b1;
            end
        end
    end

    assign o_rd_data = r_cnt[i_rd_idx];
    assign o_total   = r_total;

endmodule

### rtl/chi_square_uniformity_test.sv
// Chi-square uniformity test: counts samples per class, evaluates at end of run.
//
// Samples arrive on i_smp (valid/ready). A sample without last_sample is
// counted and ready stays high, so such samples go back to back.
// A sample with last_sample is counted, then the run is evaluated: the
// expected count comes from a reciprocal multiply, the squared deviations
// are summed through the same multiplier (square in S_SQ, add in S_ACC for
// each class), and the statistic takes the bit-serial divider (72 steps).
// A last sample keeps i_smp not ready until the result is loaded into the
// output register, and o_res.valid rises in the same cycle that i_smp.ready
// returns; a run whose expected count is zero skips the squares and the
// divider. One transfer on o_res follows each last sample. The result sits
// in an output register; further samples are taken while it waits, but a new
// evaluation holds (input not ready) until the receiver takes the previous
// result. Counters clear after each evaluation. Reset clears counters, drops
// o_res.valid and returns critical_value to 4332 (16.92 with 8 fraction
// bits). critical_value is written over the APB port where paddr[3] is clear.
module chi_square_uniformity_test import csu_pkg::*; #(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    csu_sample_if.sink            i_smp,
    csu_result_if.source          o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    localparam int IDX_W  = $clog2(NUM_CLASSES);
    localparam int SQ_W   = 2 * COUNT_BITS;
    localparam int MUL_W  = 2 * COUNT_BITS + 2;
    localparam int STEP_W = $clog2(DIV_W+1);
    // floor(x / NUM_CLASSES) == (x * REC_M) >> REC_SH for any COUNT_BITS-wide x
    localparam int                  REC_SH   = COUNT_BITS + IDX_W;
    localparam longint unsigned     REC_FULL = ((64'd1 << REC_SH) + 64'(NUM_CLASSES)
                                               - 64'd1) / 64'(NUM_CLASSES);
    localparam logic [COUNT_BITS:0] REC_M    = (COUNT_BITS+1)'(REC_FULL);

    t_state r_state, n_state;

    logic [CHI_W-1:0]      r_crit;
    logic [COUNT_BITS-1:0] r_exp;
    logic [IDX_W-1:0]      r_idx;
    logic [SQ_W-1:0]       r_sq;
    logic [SUM_W-1:0]      r_sum;
    logic [CHI_W-1:0]      r_chi;
    logic                  r_err;

    logic                  r_out_valid;
    logic [CHI_W-1:0]      r_out_chi;
    logic [TOTAL_W-1:0]    r_out_total;
    logic [EXP_W-1:0]      r_out_exp;
    logic                  r_out_acc;
    logic                  r_out_err;

    logic                  w_ready;
    logic                  w_accept;
    logic [IDX_W-1:0]      w_cls;
    logic                  w_cnt_clr;
    logic [COUNT_BITS-1:0] w_obs;
    logic [COUNT_BITS-1:0] w_total;
    logic [COUNT_BITS-1:0] w_dev;
    logic [COUNT_BITS:0]   w_mul_a;
    logic [COUNT_BITS:0]   w_mul_b;
    logic [MUL_W-1:0]      w_mul_p;
    logic [COUNT_BITS-1:0] w_exp_q;
    logic [SUM_W:0]        w_sum_add;
    logic                  w_div_start;
    logic [DIV_W-1:0]      w_div_dividend;
    logic [COUNT_BITS-1:0] w_div_divisor;
    logic [STEP_W-1:0]     w_div_steps;
    logic                  w_div_done;
    logic [DIV_W-1:0]      w_div_quo;
    logic                  w_exp_zero;
    logic                  w_out_free;
    logic                  w_load_out;
    logic                  w_cfg_wr;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[3] == REG_CRIT);
    assign prdata   = (paddr[3] == REG_CRIT) ? APB_DATA_W'(r_crit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crit <= CRIT_RESET;
        end else if (w_cfg_wr) begin
            r_crit <= pwdata[CHI_W-1:0];
        end
    end

    // sample classification
    assign w_accept = i_smp.valid && w_ready;
    assign w_cls    = (i_smp.sample_value < SAMPLE_W'(NUM_CLASSES-1))
                    ? i_smp.sample_value[IDX_W-1:0] : IDX_W'(NUM_CLASSES-1);

    csu_cnt #(
        .N (NUM_CLASSES),
        .W (COUNT_BITS)
    ) u_cnt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_inc     (w_accept),
        .i_cls     (w_cls),
        .i_clr     (w_cnt_clr),
        .i_rd_idx  (r_idx),
        .o_rd_data (w_obs),
        .o_total   (w_total)
    );

    csu_div #(
        .DDW (DIV_W),
        .DVW (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .i_steps    (w_div_steps),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // one multiplier: reciprocal for the expected count, then the squares
    assign w_dev      = (w_obs >= r_exp) ? (w_obs - r_exp) : (r_exp - w_obs);
    assign w_mul_a    = (r_state == S_EXP) ? {1'b0, w_total} : {1'b0, w_dev};
    assign w_mul_b    = (r_state == S_EXP) ? REC_M : {1'b0, w_dev};
    assign w_mul_p    = MUL_W'(w_mul_a) * MUL_W'(w_mul_b);
    assign w_exp_q    = COUNT_BITS'(w_mul_p >> REC_SH);
    assign w_exp_zero = (w_exp_q == '0);

    assign w_sum_add  = {1'b0, r_sum} + {1'b0, SUM_W'(r_sq)};
    assign w_out_free = !r_out_valid || o_res.ready;

    assign w_div_dividend = {r_sum, FRAC_BITS'(0)};
    assign w_div_divisor  = r_exp;
    assign w_div_steps    = STEP_W'(DIV_W);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (w_accept && i_smp.last_sample) n_state = S_EXP;
            S_EXP:      n_state = w_exp_zero ? S_OUT : S_SQ;
            S_SQ:       n_state = S_ACC;
            S_ACC:      n_state = (r_idx == IDX_W'(NUM_CLASSES-1)) ? S_CHI_GO : S_SQ;
            S_CHI_GO:   n_state = S_CHI_WAIT;
            S_CHI_WAIT: if (w_div_done) n_state = S_OUT;
            S_OUT:      if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_ready     = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            S_IDLE:   w_ready     = 1'b1;
            S_CHI_GO: w_div_start = 1'b1;
            S_OUT:    w_load_out  = w_out_free;
            default:  w_ready     = 1'b0;
        endcase
    end

    assign w_cnt_clr = w_load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // evaluation datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXP) begin
            r_exp <= w_exp_q;
            r_err <= w_exp_zero;
            r_idx <= '0;
            r_sum <= '0;
            r_chi <= '0;
        end
        if (r_state == S_SQ) begin
            r_sq <= w_mul_p[SQ_W-1:0];
        end
        if (r_state == S_ACC) begin
            r_sum <= w_sum_add[SUM_W] ? '1 : w_sum_add[SUM_W-1:0];
            r_idx <= r_idx + 1'b1;
        end
        if (r_state == S_CHI_WAIT && w_div_done) begin
            r_chi <= (|w_div_quo[DIV_W-1:CHI_W]) ? CHI_MAX : w_div_quo[CHI_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_chi   <= r_chi;
            r_out_total <= (32'(w_total) > 32'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(w_total);
            r_out_exp   <= (32'(r_exp) > 32'(EXP_MAX)) ? EXP_MAX : EXP_W'(r_exp);
            r_out_acc   <= !r_err && (r_chi < r_crit);
            r_out_err   <= r_err;
        end
    end

    assign i_smp.ready          = w_ready;
    assign o_res.valid          = r_out_valid;
    assign o_res.chi_stat       = r_out_chi;
    assign o_res.total_count    = r_out_total;
    assign o_res.expected_count = r_out_exp;
    assign o_res.accepted       = r_out_acc;
    assign o_res.divide_error   = r_out_err;

endmodule

### rtl/csu_chk.sv
// Port-level checks for the chi-square uniformity test, bound to the top level.
module csu_chk import csu_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_in_last,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [CHI_W-1:0]   i_out_chi,
    input logic [TOTAL_W-1:0] i_out_total,
    input logic [EXP_W-1:0]   i_out_exp,
    input logic               i_out_acc,
    input logic               i_out_err
);

    // a pending result stays until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    // end of run starts evaluation, so input must stall next cycle
    a_eval_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("input not stalled during evaluation");

    // a divide error forces a zero statistic and rejection
    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_err |-> !i_out_acc && i_out_chi == '0)
        else $error("divide error with nonzero statistic or accept");

    // expected count never exceeds the run total and is zero exactly on error
    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (32'(i_out_exp) <= 32'(i_out_total))
                        && ((i_out_exp == '0) == i_out_err))
        else $error("expected count inconsistent with total or error flag");

endmodule

bind chi_square_uniformity_test csu_chk u_csu_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_in_last   (i_smp.last_sample),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_chi   (o_res.chi_stat),
    .i_out_total (o_res.total_count),
    .i_out_exp   (o_res.expected_count),
    .i_out_acc   (o_res.accepted),
    .i_out_err   (o_res.divide_error)
);
